[hw/rtl/rgb2hsv_pkg.sv]
// Shared types and constants for the RGB to HSV converter with window test.
package rgb2hsv_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Divider: 8-bit remainder, 16 quotient bits, two quotient bits per stage
  localparam int unsigned REM_W           = CHAN_W;
  localparam int unsigned QUOT_W          = 16;
  localparam int unsigned DIV_W           = REM_W + QUOT_W;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = QUOT_W / STEPS_PER_STAGE;

  // 65280 / 6: hue = n * 10880 / delta
  localparam logic [13:0] HUE_SCALE = 14'd10880;
  // 255 / 3: window test on hue uses n * 85 against bound * 2 * delta
  localparam logic [6:0]  HUE_WIN_SCALE = 7'd85;

  localparam logic [CHAN_W-1:0] HUE_LOW_RST  = 8'd0;
  localparam logic [CHAN_W-1:0] HUE_HIGH_RST = 8'd255;
  localparam logic [CHAN_W-1:0] SAT_LOW_RST  = 8'd50;
  localparam logic [CHAN_W-1:0] SAT_HIGH_RST = 8'd255;
  localparam logic [CHAN_W-1:0] VAL_LOW_RST  = 8'd0;
  localparam logic [CHAN_W-1:0] VAL_HIGH_RST = 8'd150;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_VAL_LOW  = 3'd4,
    REG_VAL_HIGH = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue_low;
    logic [CHAN_W-1:0] hue_high;
    logic [CHAN_W-1:0] sat_low;
    logic [CHAN_W-1:0] sat_high;
    logic [CHAN_W-1:0] val_low;
    logic [CHAN_W-1:0] val_high;
  } bounds_t;

  // Request between the front end and the divider pipeline
  typedef struct packed {
    logic [DIV_W-1:0]  hue_w;
    logic [DIV_W-1:0]  sat_w;
    logic [CHAN_W-1:0] hue_dv;
    logic [CHAN_W-1:0] sat_dv;
    logic [CHAN_W-1:0] value;
    logic              in_range;
  } div_item_t;

endpackage

[hw/rtl/rgb_to_hsv_pixel_with_range_test.sv]
// Top level: RGB to HSV pixel converter with a configurable HSV window test.
//
// Pixel channel: red, green, blue with pixel_valid / pixel_stall. A request
// is taken at a rising edge where pixel_valid is high and pixel_stall low.
// Result channel: hue_fixed, sat_fixed (8.8 on the 0..255 scale, truncated),
// value_out and in_range with result_valid / result_stall.
// Configuration: cfg_write, cfg_index, cfg_data write one of six 8-bit
// window bounds per cycle; indexes 6 and 7 are ignored. Write only while
// the pipeline is empty.
// Pipeline: an accepted pixel passes the front end stages (max/min,
// numerator, products, window test), then the divider stages.
// Throughput: one pixel per cycle while pixel_stall is low; the divider
// yields two quotient bits per stage over its 16-bit quotient, which sets
// the depth. Reset empties the pipeline and loads the default bounds.
// When the receiver stalls, the last stage holds its result; earlier stages
// keep filling bubbles, and pixel_stall rises only once every stage is full.
module rgb_to_hsv_pixel_with_range_test import rgb2hsv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  logic [CHAN_W-1:0]    red,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    blue,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAN_W-1:0]    cfg_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [QUOT_W-1:0]    hue_fixed,
  output logic [QUOT_W-1:0]    sat_fixed,
  output logic [CHAN_W-1:0]    value_out,
  output logic                 in_range
);

  bounds_t   bounds;
  logic      mid_valid, mid_stall;
  div_item_t mid_item, res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.hue_low  <= HUE_LOW_RST;
      bounds.hue_high <= HUE_HIGH_RST;
      bounds.sat_low  <= SAT_LOW_RST;
      bounds.sat_high <= SAT_HIGH_RST;
      bounds.val_low  <= VAL_LOW_RST;
      bounds.val_high <= VAL_HIGH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HUE_LOW:  bounds.hue_low  <= cfg_data;
        REG_HUE_HIGH: bounds.hue_high <= cfg_data;
        REG_SAT_LOW:  bounds.sat_low  <= cfg_data;
        REG_SAT_HIGH: bounds.sat_high <= cfg_data;
        REG_VAL_LOW:  bounds.val_low  <= cfg_data;
        REG_VAL_HIGH: bounds.val_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rgb2hsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_stall  (pixel_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .bounds    (bounds),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .out_item  (mid_item)
  );

  rgb2hsv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_stall  (mid_stall),
    .in_item   (mid_item),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_item  (res_item)
  );

  assign hue_fixed = res_item.hue_w[QUOT_W-1:0];
  assign sat_fixed = res_item.sat_w[QUOT_W-1:0];
  assign value_out = res_item.value;
  assign in_range  = res_item.in_range;

endmodule

[hw/rtl/rgb2hsv_front.sv]
// Front end: channel max/min, hue numerator, dividends and the HSV window test.
module rgb2hsv_front import rgb2hsv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  bounds_t           bounds,
  output logic              out_valid,
  input  logic              out_stall,
  output div_item_t         out_item
);

  logic v1, v2, v3, v4;
  logic hold1, hold2, hold3, hold4;

  // stage 1 registers
  logic [CHAN_W-1:0] s1_mx, s1_d;
  sector_t           s1_sector;
  logic signed [8:0] s1_diff;
  // stage 2 registers
  logic [CHAN_W-1:0] s2_mx, s2_d;
  logic [10:0]       s2_n;
  // stage 3 registers
  logic [CHAN_W-1:0] s3_mx, s3_d;
  logic [DIV_W-1:0]  s3_hnum, s3_snum;
  logic [16:0]       s3_h85, s3_hlo, s3_hhi;
  logic [15:0]       s3_s255, s3_slo, s3_shi;

  // a stage holds only when it is full and the one after it holds
  assign hold4    = v4 && out_stall;
  assign hold3    = v3 && hold4;
  assign hold2    = v2 && hold3;
  assign hold1    = v1 && hold2;
  assign in_stall = hold1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (!hold1) v1 <= in_valid;
      if (!hold2) v2 <= v1;
      if (!hold3) v3 <= v2;
      if (!hold4) v4 <= v3;
    end
  end

  // stage 1: maximum, minimum and sector
  logic              red_max, green_max;
  logic [CHAN_W-1:0] mx_c, mn_c;
  sector_t           sector_c;
  logic signed [8:0] diff_c;

  always_comb begin
    red_max   = (red >= green) && (red >= blue);
    green_max = !red_max && (green >= blue);
    if (red_max) begin
      mx_c     = red;
      sector_c = SEC_RED;
      diff_c   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green_max) begin
      mx_c     = green;
      sector_c = SEC_GREEN;
      diff_c   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      mx_c     = blue;
      sector_c = SEC_BLUE;
      diff_c   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    if ((red <= green) && (red <= blue)) begin
      mn_c = red;
    end else if (green <= blue) begin
      mn_c = green;
    end else begin
      mn_c = blue;
    end
  end

  // stage 2: hue numerator, wrapped into 0 .. 6*delta-1
  logic [10:0]        base_c, six_d_c;
  logic signed [11:0] n_raw_c, n_wrap_c;
  logic [10:0]        n_c;

  always_comb begin
    six_d_c = {1'b0, s1_d, 2'b00} + {2'b00, s1_d, 1'b0};
    case (s1_sector)
      SEC_GREEN: base_c = {2'b00, s1_d, 1'b0};
      SEC_BLUE:  base_c = {1'b0, s1_d, 2'b00};
      default:   base_c = '0;
    endcase
    n_raw_c  = $signed({1'b0, base_c}) + $signed({{3{s1_diff[8]}}, s1_diff});
    n_wrap_c = n_raw_c + $signed({1'b0, six_d_c});
    n_c      = n_raw_c[11] ? n_wrap_c[10:0] : n_raw_c[10:0];
  end

  // stage 3: dividends and window products
  logic [DIV_W-1:0] hnum_c;
  logic [16:0] h85_c, hlo_c, hhi_c;
  logic [15:0] s255_c, slo_c, shi_c;
  logic [DIV_W-1:0] snum_c;

  always_comb begin
    hnum_c = DIV_W'(s2_n) * DIV_W'(HUE_SCALE);
    snum_c = {s2_d, 16'h0000} - {8'h00, s2_d, 8'h00};
    h85_c  = 17'(s2_n) * 17'(HUE_WIN_SCALE);
    hlo_c  = 17'(bounds.hue_low) * 17'({s2_d, 1'b0});
    hhi_c  = 17'(bounds.hue_high) * 17'({s2_d, 1'b0});
    s255_c = {s2_d, 8'h00} - {8'h00, s2_d};
    slo_c  = 16'(bounds.sat_low) * 16'(s2_mx);
    shi_c  = 16'(bounds.sat_high) * 16'(s2_mx);
  end

  // stage 4: window test; a zero divisor becomes one so a zero dividend gives zero
  logic hue_ok_c, sat_ok_c, val_ok_c;

  always_comb begin
    if (s3_d == '0) begin
      hue_ok_c = (bounds.hue_low == '0);
    end else begin
      hue_ok_c = (s3_h85 >= s3_hlo) && (s3_h85 <= s3_hhi);
    end
    if (s3_mx == '0) begin
      sat_ok_c = (bounds.sat_low == '0);
    end else begin
      sat_ok_c = (s3_s255 >= s3_slo) && (s3_s255 <= s3_shi);
    end
    val_ok_c = (s3_mx >= bounds.val_low) && (s3_mx <= bounds.val_high);
  end

  always_ff @(posedge clk) begin
    if (!hold1) begin
      s1_mx     <= mx_c;
      s1_d      <= mx_c - mn_c;
      s1_sector <= sector_c;
      s1_diff   <= diff_c;
    end
    if (!hold2) begin
      s2_mx <= s1_mx;
      s2_d  <= s1_d;
      s2_n  <= n_c;
    end
    if (!hold3) begin
      s3_mx   <= s2_mx;
      s3_d    <= s2_d;
      s3_hnum <= hnum_c;
      s3_snum <= snum_c;
      s3_h85  <= h85_c;
      s3_hlo  <= hlo_c;
      s3_hhi  <= hhi_c;
      s3_s255 <= s255_c;
      s3_slo  <= slo_c;
      s3_shi  <= shi_c;
    end
    if (!hold4) begin
      out_item.hue_w    <= s3_hnum;
      out_item.sat_w    <= s3_snum;
      out_item.hue_dv   <= (s3_d == '0) ? CHAN_W'(1) : s3_d;
      out_item.sat_dv   <= (s3_mx == '0) ? CHAN_W'(1) : s3_mx;
      out_item.value    <= s3_mx;
      out_item.in_range <= hue_ok_c && sat_ok_c && val_ok_c;
    end
  end

  assign out_valid = v4;

endmodule

[hw/rtl/rgb2hsv_div.sv]
// Pipelined restoring divider, two lanes (hue and saturation), two quotient bits a stage.
module rgb2hsv_div import rgb2hsv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output div_item_t out_item
);

  // Working word: remainder on top, unused dividend bits below it, quotient
  // bits shifted in at the bottom.
  function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] w,
                                                input logic [REM_W-1:0] dv);
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic [REM_W-1:0] rem;
    logic             qbit;
    trial = {w[DIV_W-1:QUOT_W], w[QUOT_W-1]};
    diff  = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      rem  = diff[REM_W-1:0];
      qbit = 1'b1;
    end else begin
      rem  = trial[REM_W-1:0];
      qbit = 1'b0;
    end
    return {rem, w[QUOT_W-2:0], qbit};
  endfunction

  function automatic div_item_t div_advance(input div_item_t it);
    div_item_t res;
    res = it;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      res.hue_w = div_step(res.hue_w, res.hue_dv);
      res.sat_w = div_step(res.sat_w, res.sat_dv);
    end
    return res;
  endfunction

  logic      valid    [DIV_STAGES];
  div_item_t stage_q  [DIV_STAGES];
  logic      src_valid[DIV_STAGES];
  div_item_t src_item [DIV_STAGES];
  div_item_t stage_nx [DIV_STAGES];
  logic [DIV_STAGES:0] hold;

  always_comb begin
    src_valid[0] = in_valid;
    src_item[0]  = in_item;
    for (int k = 1; k < DIV_STAGES; k++) begin
      src_valid[k] = valid[k-1];
      src_item[k]  = stage_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      stage_nx[k] = div_advance(src_item[k]);
    end
  end

  // hold chain from the output back to the input
  always_comb begin
    hold[DIV_STAGES] = out_stall;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      hold[k] = valid[k] && hold[k+1];
    end
  end

  assign in_stall = hold[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) valid[k] <= 1'b0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (!hold[k]) valid[k] <= src_valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (!hold[k]) stage_q[k] <= stage_nx[k];
    end
  end

  assign out_valid = valid[DIV_STAGES-1];
  assign out_item  = stage_q[DIV_STAGES-1];

endmodule

[hw/rtl/rgb2hsv_check.sv]
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rgb2hsv_check import rgb2hsv_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_stall,
  input logic [QUOT_W-1:0]    hue_fixed,
  input logic [QUOT_W-1:0]    sat_fixed,
  input logic [CHAN_W-1:0]    value_out,
  input logic                 in_range
);

  // reset drains the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // held result request keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(hue_fixed) &&
      $stable(sat_fixed) && $stable(value_out) && $stable(in_range))
    else $error("stalled result changed");

  // black pixel has no saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    result_valid && (value_out == '0) |-> (sat_fixed == '0))
    else $error("saturation nonzero for black pixel");

  // grey pixel (no saturation) has hue zero
  a_grey: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sat_fixed == '0) |-> (hue_fixed == '0))
    else $error("hue nonzero for grey pixel");

  // hue stays below a full turn, saturation at most full scale
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hue_fixed <= 16'd65279) && (sat_fixed <= 16'd65280))
    else $error("hue or saturation out of scale");

endmodule

bind rgb_to_hsv_pixel_with_range_test rgb2hsv_check u_check (.*);

[bench/rgb_to_hsv_pixel_with_range_test_test.sv]
// Self-checking bench for the RGB to HSV converter and its HSV window flag.
module rgb_to_hsv_pixel_with_range_test_test import rgb2hsv_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;
  localparam int FULL_SCALE  = 255;
  localparam int FIXED_SCALE = 65280;
  localparam int RANDOM_PER_PHASE = 235;
  localparam int NUM_PHASES = 8;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [QUOT_W-1:0] hue;
    logic [QUOT_W-1:0] sat;
    logic [CHAN_W-1:0] value;
    logic              in_range;
  } hsv_result_t;

  class hsv_scoreboard;
    bounds_t     window;
    hsv_result_t expected_hsv[$];
    int          mismatches;

    function new();
      window = '{HUE_LOW_RST, HUE_HIGH_RST, SAT_LOW_RST, SAT_HIGH_RST,
                 VAL_LOW_RST, VAL_HIGH_RST};
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] data);
      case (cfg_reg_t'(idx))
        REG_HUE_LOW:  window.hue_low  = data;
        REG_HUE_HIGH: window.hue_high = data;
        REG_SAT_LOW:  window.sat_low  = data;
        REG_SAT_HIGH: window.sat_high = data;
        REG_VAL_LOW:  window.val_low  = data;
        REG_VAL_HIGH: window.val_high = data;
        default: ;
      endcase
    endfunction

    function hsv_result_t convert_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                        logic [CHAN_W-1:0] b);
      hsv_result_t res;
      int ri, gi, bi, mx, mn, d, n, den;
      logic ok;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      mx = ri;
      mn = ri;
      if (gi > mx) mx = gi;
      if (bi > mx) mx = bi;
      if (gi < mn) mn = gi;
      if (bi < mn) mn = bi;
      d = mx - mn;
      res = '0;
      ok = 1'b1;
      if (d != 0) begin
        // red wins ties over green, green over blue
        if (ri == mx) n = gi - bi;
        else if (gi == mx) n = 2 * d + (bi - ri);
        else n = 4 * d + (ri - gi);
        if (n < 0) n += 6 * d;
        den = 6 * d;
        res.hue = QUOT_W'((n * FIXED_SCALE) / den);
        // compare the exact hue, not the truncated one
        if (n * FULL_SCALE < int'(window.hue_low) * den) ok = 1'b0;
        if (n * FULL_SCALE > int'(window.hue_high) * den) ok = 1'b0;
      end else if (window.hue_low != 0) begin
        ok = 1'b0;
      end
      if (mx != 0) begin
        res.sat = QUOT_W'((d * FIXED_SCALE) / mx);
        if (d * FULL_SCALE < int'(window.sat_low) * mx) ok = 1'b0;
        if (d * FULL_SCALE > int'(window.sat_high) * mx) ok = 1'b0;
      end else if (window.sat_low != 0) begin
        ok = 1'b0;
      end
      if (mx < int'(window.val_low) || mx > int'(window.val_high)) ok = 1'b0;
      res.value = CHAN_W'(mx);
      res.in_range = ok;
      return res;
    endfunction

    function void note_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
      expected_hsv.insert(expected_hsv.size(), convert_pixel(r, g, b));
    endfunction

    function void check_result(hsv_result_t got);
      hsv_result_t want;
      if (expected_hsv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hue %0d sat %0d val %0d in_range %0b",
                   got.hue, got.sat, got.value, got.in_range);
      end else begin
        want = expected_hsv.pop_front();
        if (got.hue != want.hue || got.sat != want.sat || got.value != want.value ||
            got.in_range != want.in_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected hue %0d sat %0d val %0d in_range %0b, ",
                      "got hue %0d sat %0d val %0d in_range %0b"},
                     want.hue, want.sat, want.value, want.in_range,
                     got.hue, got.sat, got.value, got.in_range);
        end
      end
    endfunction

    function int pending();
      return expected_hsv.size();
    endfunction

    function bit failed();
      return mismatches != 0;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  logic [CHAN_W-1:0]    red = '0;
  logic [CHAN_W-1:0]    green = '0;
  logic [CHAN_W-1:0]    blue = '0;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CHAN_W-1:0]    cfg_data = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [QUOT_W-1:0]    hue_fixed;
  logic [QUOT_W-1:0]    sat_fixed;
  logic [CHAN_W-1:0]    value_out;
  logic                 in_range;

  hsv_scoreboard sb = new();
  int send_idle_pct = 26;
  int recv_idle_pct = 76;

  // grey, black, primaries, ties, hue wrap and value bound corners
  logic [23:0] corner_pixels [23] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'h010000, 24'h000100,
    24'h000001, 24'hFFFE00, 24'h643296, 24'hC80A3C, 24'h0AC81E, 24'h1E0AC8,
    24'hFEFFFD, 24'h000102, 24'h964B00, 24'h970000, 24'h323130
  };

  rgb_to_hsv_pixel_with_range_test dut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .hue_fixed(hue_fixed),
    .sat_fixed(sat_fixed),
    .value_out(value_out),
    .in_range(in_range)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("rgb_to_hsv_pixel_with_range_test_test: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall)
        sb.check_result('{hue_fixed, sat_fixed, value_out, in_range});
      if (pixel_valid && !pixel_stall)
        sb.note_pixel(red, green, blue);
    end
  end

  function automatic logic [23:0] random_pixel();
    logic [CHAN_W-1:0] c [3];
    logic [CHAN_W-1:0] m;
    int kind, k, t;
    kind = $urandom_range(99);
    m = CHAN_W'($urandom);
    for (k = 0; k < 3; k++) c[k] = CHAN_W'($urandom);
    if (kind < 45) begin
    end else if (kind < 55) begin
      c = '{m, m, m};
    end else if (kind < 67) begin
      // two channels share the maximum
      k = $urandom_range(2);
      c[k] = m;
      c[(k + 1) % 3] = m;
      c[(k + 2) % 3] = CHAN_W'($urandom_range(int'(m)));
    end else if (kind < 79) begin
      for (k = 0; k < 3; k++) begin
        t = int'(m) + int'($urandom_range(6)) - 3;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        c[k] = CHAN_W'(t);
      end
    end else if (kind < 90) begin
      for (k = 0; k < 3; k++) begin
        case ($urandom_range(2))
          0: c[k] = '0;
          1: c[k] = '1;
          default: ;
        endcase
      end
    end else begin
      for (k = 0; k < 3; k++) c[k] = $urandom_range(1) ? m : '0;
    end
    return {c[0], c[1], c[2]};
  endfunction

  function automatic logic [15:0] ordered_pair();
    logic [CHAN_W-1:0] a, b;
    a = CHAN_W'($urandom);
    b = CHAN_W'($urandom);
    return (a <= b) ? {a, b} : {b, a};
  endfunction

  function automatic bounds_t random_window();
    bounds_t w;
    {w.hue_low, w.hue_high} = ordered_pair();
    {w.sat_low, w.sat_high} = ordered_pair();
    {w.val_low, w.val_high} = ordered_pair();
    return w;
  endfunction

  task automatic send_pixel(input logic [23:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    {red, green, blue} <= px;
    do @(posedge clk); while (pixel_stall);
  endtask

  // hold off new requests until every result is back
  task automatic drain_pixels();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int count, input bit mid_pause);
    int i;
    for (i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) drain_pixels();
      send_pixel(random_pixel());
    end
  endtask

  task automatic config_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CHAN_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic write_bounds(input bounds_t w);
    config_write(REG_HUE_LOW, w.hue_low);
    config_write(REG_HUE_HIGH, w.hue_high);
    config_write(REG_SAT_LOW, w.sat_low);
    config_write(REG_SAT_HIGH, w.sat_high);
    config_write(REG_VAL_LOW, w.val_low);
    config_write(REG_VAL_HIGH, w.val_high);
    // unused indexes must leave the window alone
    config_write(IDX_SPARE_A, CHAN_W'($urandom));
    config_write(IDX_SPARE_B, CHAN_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  initial begin
    int phase;
    bounds_t w;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset window first
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    send_random(RANDOM_PER_PHASE, 1'b0);
    drain_pixels();

    for (phase = 1; phase < NUM_PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 76;
      end else if (phase < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        1: w = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        2: w = '{8'd85, 8'd170, 8'd255, 8'd255, 8'd0, 8'd255};
        3: w = '{8'd200, 8'd100, 8'd150, 8'd20, 8'd255, 8'd0};
        4: w = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        5: w = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
        default: w = random_window();
      endcase
      write_bounds(w);
      send_random(RANDOM_PER_PHASE, phase[0]);
      drain_pixels();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!sb.failed())
      $display("rgb_to_hsv_pixel_with_range_test_test: PASS");
    else
      $display("rgb_to_hsv_pixel_with_range_test_test: FAIL");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rgb2hsv_pkg.sv
hw/rtl/rgb2hsv_front.sv
hw/rtl/rgb2hsv_div.sv
hw/rtl/rgb_to_hsv_pixel_with_range_test.sv
hw/rtl/rgb2hsv_check.sv
bench/rgb_to_hsv_pixel_with_range_test_test.sv
